/* hdl/wrhp_pkg.sv */
// Shared types and constants for the RIFF/WAVE header parser.
// No dependencies; imported by wav_riff_header_parser.
package wrhp_pkg;

  localparam int MAX_TEXT = 63;
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W = $clog2(FIFO_DEPTH);

  localparam logic [1:0] KIND_CHAR   = 2'd0;
  localparam logic [1:0] KIND_END    = 2'd1;
  localparam logic [1:0] KIND_HEADER = 2'd2;
  localparam logic [1:0] KIND_ERROR  = 2'd3;

  localparam logic [1:0] TXT_OTHER = 2'd3;

  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;
  localparam logic [31:0] TAG_LIST = 32'h4C49_5354;
  localparam logic [31:0] TAG_INFO = 32'h494E_464F;
  localparam logic [31:0] TAG_INAM = 32'h494E_414D;
  localparam logic [31:0] TAG_IART = 32'h4941_5254;
  localparam logic [31:0] TAG_IPRD = 32'h4950_5244;

  localparam logic [3:0] PH_RIFF  = 4'd0;
  localparam logic [3:0] PH_RSIZE = 4'd1;
  localparam logic [3:0] PH_WAVE  = 4'd2;
  localparam logic [3:0] PH_CTAG  = 4'd3;
  localparam logic [3:0] PH_CSIZE = 4'd4;
  localparam logic [3:0] PH_FMT   = 4'd5;
  localparam logic [3:0] PH_LTYPE = 4'd6;
  localparam logic [3:0] PH_SID   = 4'd7;
  localparam logic [3:0] PH_SSIZE = 4'd8;
  localparam logic [3:0] PH_SVAL  = 4'd9;
  localparam logic [3:0] PH_SKIP  = 4'd10;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  field;
    logic [7:0]  char_v;
    logic [15:0] chans;
    logic [31:0] rate;
    logic [15:0] bits;
    logic [31:0] size;
    logic        last;
  } res_t;

  function automatic res_t mk_res(input logic [1:0] kind, input logic [1:0] field,
                                  input logic [7:0] char_v, input logic [15:0] chans,
                                  input logic [31:0] rate, input logic [15:0] bits,
                                  input logic [31:0] size);
    res_t r;
    r.kind   = kind;
    r.field  = field;
    r.char_v = char_v;
    r.chans  = chans;
    r.rate   = rate;
    r.bits   = bits;
    r.size   = size;
    r.last   = 1'b0;
    return r;
  endfunction

endpackage

/* hdl/wav_riff_header_parser.sv */
// RIFF/WAVE header parser: byte-wide parse state plus a small result queue.
// Depends on wrhp_pkg.
//
// One byte of a WAV file is taken per beat and parsed in the cycle it is
// accepted; its zero, one or two results enter a four-entry output queue that
// drains one result per beat. A byte is taken in every cycle while the queue
// holds at most two results, so with out_ready high the input runs at one byte
// per cycle except where a byte gives two results (the last character of a
// text value) and the single output port sets the pace. Results: text
// characters and end markers for INAM, IART and IPRD, then one header report
// at the data chunk or one error; run_last marks the final result of a byte.
// After a report all bytes are dropped until first_byte restarts the parse.
module wav_riff_header_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_first_byte,
  input  logic        in_end_of_file,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_result_kind,
  output logic [1:0]  out_text_field,
  output logic [7:0]  out_text_char,
  output logic [15:0] out_channel_count,
  output logic [31:0] out_sample_rate,
  output logic [15:0] out_sample_bits,
  output logic [31:0] out_payload_size,
  output logic        out_run_last
);
  import wrhp_pkg::*;

  logic [3:0]  phase_r, phase_nxt;
  logic [4:0]  offset_r, offset_nxt;
  logic [32:0] chunk_left_r, chunk_left_nxt;
  logic [32:0] list_left_r, list_left_nxt;
  logic [32:0] sub_left_r, sub_left_nxt;
  logic [31:0] tag_r, tag_nxt;
  logic [31:0] size_r, size_nxt;
  logic [15:0] fmt_chans_r, fmt_chans_nxt;
  logic [31:0] fmt_rate_r, fmt_rate_nxt;
  logic [15:0] fmt_bits_r, fmt_bits_nxt;
  logic        fmt_seen_r, fmt_seen_nxt;
  logic [1:0]  text_kind_r, text_kind_nxt;
  logic [7:0]  text_count_r, text_count_nxt;
  logic        text_stop_r, text_stop_nxt;
  logic        fin_r, fin_nxt;

  res_t              fifo_r [FIFO_DEPTH];
  logic [PTR_W-1:0]  wptr_r, rptr_r;
  logic [PTR_W:0]    cnt_r, cnt_nxt;

  res_t        res [2];
  logic [1:0]  nres;
  logic        do_after, do_enter;
  logic [32:0] padded;
  logic        in_fire, out_fire;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;
  assign in_ready = cnt_r <= (PTR_W+1)'(FIFO_DEPTH - 2);

  always_comb begin
    phase_nxt      = phase_r;
    offset_nxt     = offset_r;
    chunk_left_nxt = chunk_left_r;
    list_left_nxt  = list_left_r;
    sub_left_nxt   = sub_left_r;
    tag_nxt        = tag_r;
    size_nxt       = size_r;
    fmt_chans_nxt  = fmt_chans_r;
    fmt_rate_nxt   = fmt_rate_r;
    fmt_bits_nxt   = fmt_bits_r;
    fmt_seen_nxt   = fmt_seen_r;
    text_kind_nxt  = text_kind_r;
    text_count_nxt = text_count_r;
    text_stop_nxt  = text_stop_r;
    fin_nxt        = fin_r;
    res[0]   = '0;
    res[1]   = '0;
    nres     = 2'd0;
    do_after = 1'b0;
    do_enter = 1'b0;
    padded   = '0;

    if (in_first_byte) begin
      phase_nxt      = PH_RIFF;
      offset_nxt     = '0;
      chunk_left_nxt = '0;
      list_left_nxt  = '0;
      sub_left_nxt   = '0;
      tag_nxt        = '0;
      size_nxt       = '0;
      fmt_chans_nxt  = '0;
      fmt_rate_nxt   = '0;
      fmt_bits_nxt   = '0;
      fmt_seen_nxt   = 1'b0;
      text_kind_nxt  = '0;
      text_count_nxt = '0;
      text_stop_nxt  = 1'b0;
      fin_nxt        = 1'b0;
    end

    if (!fin_nxt) begin
      unique case (phase_nxt)
        PH_RIFF, PH_WAVE, PH_CTAG, PH_LTYPE, PH_SID: begin
          tag_nxt    = {tag_nxt[23:0], in_data_byte};
          offset_nxt = offset_nxt + 5'd1;
          if (phase_nxt == PH_LTYPE) chunk_left_nxt = chunk_left_nxt - 33'd1;
          else if (phase_nxt == PH_SID) list_left_nxt = list_left_nxt - 33'd1;
          if (offset_nxt == 5'd4) begin
            offset_nxt = '0;
            priority case (phase_nxt)
              PH_RIFF: begin
                if (tag_nxt == TAG_RIFF) phase_nxt = PH_RSIZE;
                else begin
                  res[0] = mk_res(KIND_ERROR, 2'd0, 8'd0, 16'd0, 32'd0, 16'd0, 32'd0);
                  nres = 2'd1;
                  fin_nxt = 1'b1;
                end
              end
              PH_WAVE: begin
                if (tag_nxt == TAG_WAVE) phase_nxt = PH_CTAG;
                else begin
                  res[0] = mk_res(KIND_ERROR, 2'd0, 8'd0, 16'd0, 32'd0, 16'd0, 32'd0);
                  nres = 2'd1;
                  fin_nxt = 1'b1;
                end
              end
              PH_CTAG: begin
                size_nxt  = '0;
                phase_nxt = PH_CSIZE;
              end
              PH_LTYPE: begin
                if (tag_nxt == TAG_INFO) begin
                  list_left_nxt  = chunk_left_nxt;
                  chunk_left_nxt = '0;
                  do_enter = 1'b1;
                end else begin
                  phase_nxt = (chunk_left_nxt != '0) ? PH_SKIP : PH_CTAG;
                end
              end
              default: begin
                if (tag_nxt == TAG_INAM) text_kind_nxt = 2'd0;
                else if (tag_nxt == TAG_IART) text_kind_nxt = 2'd1;
                else if (tag_nxt == TAG_IPRD) text_kind_nxt = 2'd2;
                else text_kind_nxt = TXT_OTHER;
                size_nxt  = '0;
                phase_nxt = PH_SSIZE;
              end
            endcase
          end else if (phase_nxt == PH_LTYPE && chunk_left_nxt == '0) begin
            offset_nxt = '0;
            phase_nxt  = PH_CTAG;
          end
        end
        PH_RSIZE, PH_CSIZE, PH_SSIZE: begin
          size_nxt   = size_nxt | ({24'd0, in_data_byte} << {offset_nxt[1:0], 3'b000});
          offset_nxt = offset_nxt + 5'd1;
          if (phase_nxt == PH_SSIZE) list_left_nxt = list_left_nxt - 33'd1;
          if (offset_nxt == 5'd4) begin
            padded     = {1'b0, size_nxt} + {32'd0, size_nxt[0]};
            offset_nxt = '0;
            if (phase_nxt == PH_RSIZE) begin
              phase_nxt = PH_WAVE;
            end else if (phase_nxt == PH_SSIZE) begin
              text_count_nxt = (size_nxt < 32'(MAX_TEXT)) ? size_nxt[7:0] : 8'(MAX_TEXT);
              sub_left_nxt   = padded;
              text_stop_nxt  = 1'b0;
              if (text_count_nxt == 8'd0) begin
                if (text_kind_nxt != TXT_OTHER) begin
                  res[0] = mk_res(KIND_END, text_kind_nxt, 8'd0, 16'd0, 32'd0, 16'd0, 32'd0);
                  nres = 2'd1;
                end
                text_stop_nxt = 1'b1;
              end
              do_after = 1'b1;
            end else if (tag_nxt == TAG_DATA) begin
              if (fmt_seen_nxt) begin
                res[0] = mk_res(KIND_HEADER, 2'd0, 8'd0, fmt_chans_nxt, fmt_rate_nxt,
                                fmt_bits_nxt, size_nxt);
              end else begin
                res[0] = mk_res(KIND_ERROR, 2'd0, 8'd0, 16'd0, 32'd0, 16'd0, 32'd0);
              end
              nres = 2'd1;
              fin_nxt = 1'b1;
            end else begin
              chunk_left_nxt = padded;
              if (tag_nxt == TAG_FMT) begin
                fmt_chans_nxt = '0;
                fmt_rate_nxt  = '0;
                fmt_bits_nxt  = '0;
                fmt_seen_nxt  = 1'b1;
                phase_nxt = (padded != '0) ? PH_FMT : PH_CTAG;
              end else if (tag_nxt == TAG_LIST) begin
                phase_nxt = (padded != '0) ? PH_LTYPE : PH_CTAG;
              end else begin
                phase_nxt = (padded != '0) ? PH_SKIP : PH_CTAG;
              end
            end
          end
        end
        PH_FMT: begin
          priority case (offset_nxt)
            5'd2:  fmt_chans_nxt[7:0]   = in_data_byte;
            5'd3:  fmt_chans_nxt[15:8]  = in_data_byte;
            5'd4:  fmt_rate_nxt[7:0]    = in_data_byte;
            5'd5:  fmt_rate_nxt[15:8]   = in_data_byte;
            5'd6:  fmt_rate_nxt[23:16]  = in_data_byte;
            5'd7:  fmt_rate_nxt[31:24]  = in_data_byte;
            5'd14: fmt_bits_nxt[7:0]    = in_data_byte;
            5'd15: fmt_bits_nxt[15:8]   = in_data_byte;
            default: ;
          endcase
          if (offset_nxt < 5'd16) offset_nxt = offset_nxt + 5'd1;
          chunk_left_nxt = chunk_left_nxt - 33'd1;
          if (chunk_left_nxt == '0) begin
            offset_nxt = '0;
            phase_nxt  = PH_CTAG;
          end
        end
        PH_SVAL: begin
          sub_left_nxt  = sub_left_nxt - 33'd1;
          list_left_nxt = list_left_nxt - 33'd1;
          if (text_count_nxt != 8'd0) begin
            text_count_nxt = text_count_nxt - 8'd1;
            if (text_kind_nxt != TXT_OTHER && !text_stop_nxt) begin
              if (in_data_byte == 8'd0) begin
                res[0] = mk_res(KIND_END, text_kind_nxt, 8'd0, 16'd0, 32'd0, 16'd0, 32'd0);
                nres = 2'd1;
                text_stop_nxt = 1'b1;
              end else begin
                res[0] = mk_res(KIND_CHAR, text_kind_nxt, in_data_byte, 16'd0, 32'd0,
                                16'd0, 32'd0);
                nres = 2'd1;
                if (text_count_nxt == 8'd0) begin
                  res[1] = mk_res(KIND_END, text_kind_nxt, 8'd0, 16'd0, 32'd0, 16'd0, 32'd0);
                  nres = 2'd2;
                  text_stop_nxt = 1'b1;
                end
              end
            end
          end
          if (list_left_nxt == '0 && text_kind_nxt != TXT_OTHER && !text_stop_nxt) begin
            res[nres[0]] = mk_res(KIND_END, text_kind_nxt, 8'd0, 16'd0, 32'd0, 16'd0, 32'd0);
            nres = nres + 2'd1;
            text_stop_nxt = 1'b1;
          end
          do_after = 1'b1;
        end
        default: begin
          if (chunk_left_nxt != '0) chunk_left_nxt = chunk_left_nxt - 33'd1;
          if (chunk_left_nxt == '0) begin
            offset_nxt = '0;
            phase_nxt  = PH_CTAG;
          end
        end
      endcase

      if (do_after) begin
        if (list_left_nxt == '0) phase_nxt = PH_CTAG;
        else if (sub_left_nxt == '0) do_enter = 1'b1;
        else phase_nxt = PH_SVAL;
      end
      if (do_enter) begin
        offset_nxt = '0;
        if (list_left_nxt == '0) begin
          phase_nxt = PH_CTAG;
        end else if (list_left_nxt < 33'd8) begin
          chunk_left_nxt = list_left_nxt;
          list_left_nxt  = '0;
          phase_nxt      = PH_SKIP;
        end else begin
          phase_nxt = PH_SID;
        end
      end

      if (in_end_of_file && !fin_nxt) begin
        res[0] = mk_res(KIND_ERROR, 2'd0, 8'd0, 16'd0, 32'd0, 16'd0, 32'd0);
        nres = 2'd1;
        fin_nxt = 1'b1;
      end
      if (nres == 2'd2) res[1].last = 1'b1;
      else if (nres == 2'd1) res[0].last = 1'b1;
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (in_fire) cnt_nxt = cnt_nxt + {{(PTR_W-1){1'b0}}, nres};
    if (out_fire) cnt_nxt = cnt_nxt - (PTR_W+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_RIFF;
      offset_r     <= '0;
      chunk_left_r <= '0;
      list_left_r  <= '0;
      sub_left_r   <= '0;
      tag_r        <= '0;
      size_r       <= '0;
      fmt_chans_r  <= '0;
      fmt_rate_r   <= '0;
      fmt_bits_r   <= '0;
      fmt_seen_r   <= 1'b0;
      text_kind_r  <= '0;
      text_count_r <= '0;
      text_stop_r  <= 1'b0;
      fin_r        <= 1'b0;
      wptr_r       <= '0;
      rptr_r       <= '0;
      cnt_r        <= '0;
    end else begin
      if (in_fire) begin
        phase_r      <= phase_nxt;
        offset_r     <= offset_nxt;
        chunk_left_r <= chunk_left_nxt;
        list_left_r  <= list_left_nxt;
        sub_left_r   <= sub_left_nxt;
        tag_r        <= tag_nxt;
        size_r       <= size_nxt;
        fmt_chans_r  <= fmt_chans_nxt;
        fmt_rate_r   <= fmt_rate_nxt;
        fmt_bits_r   <= fmt_bits_nxt;
        fmt_seen_r   <= fmt_seen_nxt;
        text_kind_r  <= text_kind_nxt;
        text_count_r <= text_count_nxt;
        text_stop_r  <= text_stop_nxt;
        fin_r        <= fin_nxt;
        wptr_r       <= wptr_r + PTR_W'(nres);
      end
      if (out_fire) rptr_r <= rptr_r + PTR_W'(1);
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && nres != 2'd0) fifo_r[wptr_r] <= res[0];
    if (in_fire && nres == 2'd2) fifo_r[wptr_r + PTR_W'(1)] <= res[1];
  end

  assign out_valid         = cnt_r != '0;
  assign out_result_kind   = fifo_r[rptr_r].kind;
  assign out_text_field    = fifo_r[rptr_r].field;
  assign out_text_char     = fifo_r[rptr_r].char_v;
  assign out_channel_count = fifo_r[rptr_r].chans;
  assign out_sample_rate   = fifo_r[rptr_r].rate;
  assign out_sample_bits   = fifo_r[rptr_r].bits;
  assign out_payload_size  = fifo_r[rptr_r].size;
  assign out_run_last      = fifo_r[rptr_r].last;

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (PTR_W+1)'(FIFO_DEPTH))
    else $error("result queue overflow");

  a_fin_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && fin_r && !in_first_byte && !out_fire |=> cnt_r == $past(cnt_r))
    else $error("result queued after parse finished");

  a_pair_whole: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && !out_run_last |=> out_valid)
    else $error("second result of a byte missing");

  a_sval_list: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_SVAL |-> list_left_r != '0)
    else $error("value phase with empty LIST");
`endif

endmodule
